@@ sv/awfm_pkg.sv @@
// Shared types and constants for the ADC window frequency monitor.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package awfm_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int WINDOW_DEF    = 128;
    localparam int DEC_BITS      = 8;
    localparam int TICK_BITS     = 32;
    localparam int HALF_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [DEC_BITS-1:0]    DECIMATION_RST = DEC_BITS'(1);
    localparam logic [SAMPLE_BITS-1:0] MIDPOINT_RST   = SAMPLE_BITS'(2048);
    localparam logic [SAMPLE_BITS-1:0] MARGIN_RST     = SAMPLE_BITS'(2047);
    localparam logic [HALF_BITS-1:0]   HALF_MAX       = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DECIMATION = 2'd0,
        CFG_MIDPOINT   = 2'd1,
        CFG_MARGIN     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_WAIT_RISE = 2'd0,
        PH_COUNT     = 2'd1,
        PH_STORE     = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } t_state;

    typedef struct packed {
        logic [DEC_BITS-1:0]    decimation;
        logic [SAMPLE_BITS-1:0] midpoint;
        logic [SAMPLE_BITS-1:0] margin;
    } t_cfg;

    typedef struct packed {
        logic                 overload_seen;
        logic [TICK_BITS-1:0] overload_tick;
        logic [HALF_BITS-1:0] half_period;
        logic [TICK_BITS-1:0] tick_count;
    } t_trk_sts;

    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] data;
    } t_scan_ctl;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] max;
        logic [SAMPLE_BITS-1:0] min;
    } t_scan_sts;

endpackage

@@ sv/awfm_if.sv @@
// Handshake channel interfaces: sample input, result output, config writes.
// Depends on awfm_pkg.
`timescale 1ns / 1ps

interface awfm_in_if
    import awfm_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface awfm_out_if
    import awfm_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   taken;
    logic                   overload_seen;
    logic [TICK_BITS-1:0]   overload_tick;
    logic [SAMPLE_BITS-1:0] window_max;
    logic [SAMPLE_BITS-1:0] window_min;
    logic [HALF_BITS-1:0]   half_period;
    logic [TICK_BITS-1:0]   tick_count;

    modport source (output valid, output taken, output overload_seen, output overload_tick,
                    output window_max, output window_min, output half_period,
                    output tick_count, input ready);
    modport sink   (input valid, input taken, input overload_seen, input overload_tick,
                    input window_max, input window_min, input half_period,
                    input tick_count, output ready);
endinterface

interface awfm_cfg_if
    import awfm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/awfm_track.sv @@
// Per-tick bookkeeping: tick counter, decimation, overload record, crossing detector.
// Depends on awfm_pkg.
`timescale 1ns / 1ps

module awfm_track
    import awfm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_step,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_kept,
    output t_trk_sts               o_sts
);

    logic [TICK_BITS-1:0]   r_ticks;
    logic [DEC_BITS-1:0]    r_dcount;
    logic                   r_ovl_flag;
    logic [TICK_BITS-1:0]   r_ovl_stamp;
    logic [SAMPLE_BITS-1:0] r_prev;
    t_phase                 r_phase;
    logic [HALF_BITS-1:0]   r_running;
    logic [HALF_BITS-1:0]   r_last_half;

    logic [TICK_BITS-1:0]   n_ticks;
    logic [DEC_BITS-1:0]    n_dcount;
    logic [SAMPLE_BITS:0]   ovl_limit;
    logic                   overload;
    logic                   rise;
    logic                   fall;

    assign n_ticks   = r_ticks + TICK_BITS'(1);
    assign n_dcount  = r_dcount + DEC_BITS'(1);
    // zero decimation keeps every tick, same as one
    assign o_kept    = (n_dcount >= i_cfg.decimation);
    // sample - midpoint > margin, without going signed
    assign ovl_limit = {1'b0, i_cfg.midpoint} + {1'b0, i_cfg.margin};
    assign overload  = ({1'b0, i_sample} > ovl_limit);
    assign rise      = (r_prev < i_cfg.midpoint) && (i_sample > i_cfg.midpoint);
    assign fall      = (r_prev > i_cfg.midpoint) && (i_sample < i_cfg.midpoint);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= '0;
            r_dcount    <= '0;
            r_ovl_flag  <= 1'b0;
            r_ovl_stamp <= '0;
            r_prev      <= '0;
            r_phase     <= PH_WAIT_RISE;
            r_running   <= '0;
            r_last_half <= '0;
        end else if (i_step) begin
            r_ticks  <= n_ticks;
            r_dcount <= o_kept ? '0 : n_dcount;
            if (o_kept) begin
                if (overload) begin
                    r_ovl_flag  <= 1'b1;
                    r_ovl_stamp <= n_ticks;
                end
                unique case (r_phase)
                    PH_COUNT: begin
                        if (r_running != HALF_MAX) begin
                            r_running <= r_running + HALF_BITS'(1);
                        end
                        if (fall) begin
                            r_phase <= PH_STORE;
                        end
                    end
                    PH_STORE: begin
                        r_last_half <= r_running;
                        r_running   <= '0;
                        r_phase     <= PH_WAIT_RISE;
                    end
                    default: begin
                        r_running <= '0;
                        r_phase   <= rise ? PH_COUNT : PH_WAIT_RISE;
                    end
                endcase
                r_prev <= i_sample;
            end
        end
    end

    assign o_sts.overload_seen = r_ovl_flag;
    assign o_sts.overload_tick = r_ovl_stamp;
    assign o_sts.half_period   = r_last_half;
    assign o_sts.tick_count    = r_ticks;

endmodule

@@ sv/awfm_scan.sv @@
// Sample window RAM plus one shared compare unit that sweeps it for max and min.
// Depends on awfm_pkg.
`timescale 1ns / 1ps

module awfm_scan
    import awfm_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    output t_scan_sts o_sts
);

    localparam int ADDR_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [ADDR_BITS-1:0] LAST = ADDR_BITS'(WINDOW - 1);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [ADDR_BITS-1:0]   r_slot;
    logic                   r_wrapped;
    logic [ADDR_BITS-1:0]   r_addr;
    logic                   r_issue;
    logic                   r_cmp;
    logic                   r_cmp_ok;
    logic                   r_cmp_last;
    logic                   r_done;
    logic [SAMPLE_BITS-1:0] r_acc_max;
    logic [SAMPLE_BITS-1:0] r_acc_min;

    logic [SAMPLE_BITS-1:0] cmp_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mem[r_slot] <= i_ctl.data;
        end
        r_rd <= r_mem[r_addr];
    end

    // never-written entries stand for the cleared value zero
    assign cmp_val = r_cmp_ok ? r_rd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_wrapped  <= 1'b0;
            r_addr     <= '0;
            r_issue    <= 1'b0;
            r_cmp      <= 1'b0;
            r_cmp_ok   <= 1'b0;
            r_cmp_last <= 1'b0;
            r_done     <= 1'b0;
            r_acc_max  <= '0;
            r_acc_min  <= '0;
        end else begin
            r_done <= r_cmp && r_cmp_last;
            if (i_ctl.start) begin
                r_slot    <= (r_slot == LAST) ? '0 : r_slot + ADDR_BITS'(1);
                r_wrapped <= r_wrapped || (r_slot == LAST);
                r_addr    <= '0;
                r_issue   <= 1'b1;
                r_acc_max <= '0;
                r_acc_min <= '1;
            end else if (r_issue) begin
                r_addr  <= r_addr + ADDR_BITS'(1);
                r_issue <= (r_addr != LAST);
            end
            r_cmp      <= r_issue;
            r_cmp_ok   <= r_wrapped || (r_addr < r_slot);
            r_cmp_last <= (r_addr == LAST);
            if (r_cmp) begin
                if (cmp_val > r_acc_max) begin
                    r_acc_max <= cmp_val;
                end
                if (cmp_val < r_acc_min) begin
                    r_acc_min <= cmp_val;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.max  = r_acc_max;
    assign o_sts.min  = r_acc_min;

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_issue && !r_cmp && !r_done)
        else $error("scan started while a sweep is running");
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_acc_min <= r_acc_max)
        else $error("sweep finished with min above max");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_cmp) && !r_issue)
        else $error("sweep done without a final compare");
`endif

endmodule

@@ sv/adc_window_frequency_monitor.sv @@
// Top level: config registers, item sequencer and result register.
// Depends on awfm_pkg, awfm_if, awfm_track and awfm_scan.
//
//  channel       dir  beat contents
//  i_sample_ch   in   sample (12 bits)
//  o_result_ch   out  taken, overload_seen, overload_tick, window_max/min,
//                     half_period, tick_count
//  i_cfg_ch      in   index (0 decimation, 1 midpoint, 2 overload_margin), data
//
// A tick whose sample is not kept skips the sweep. A kept tick writes the window
// RAM and then sweeps all WINDOW entries through one compare unit, one read a
// cycle. i_sample_ch.ready is low while a beat is in work or its result has no
// room. Config writes are always taken. Reset is synchronous, active low; the
// window starts empty and unwritten entries read as zero, so no clearing pass
// is run.
`timescale 1ns / 1ps

module adc_window_frequency_monitor
    import awfm_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    awfm_in_if.sink    i_sample_ch,
    awfm_out_if.source o_result_ch,
    awfm_cfg_if.sink   i_cfg_ch
);

    t_state    r_state, n_state;
    t_cfg      r_cfg;
    t_trk_sts  trk_sts;
    t_scan_ctl scan_ctl;
    t_scan_sts scan_sts;
    logic      kept;
    logic      in_fire;
    logic      out_load;

    logic                   r_out_valid, n_out_valid;
    logic                   r_taken;
    logic                   r_out_taken;
    logic                   r_out_ovl;
    logic [TICK_BITS-1:0]   r_out_ovl_tick;
    logic [SAMPLE_BITS-1:0] r_out_max;
    logic [SAMPLE_BITS-1:0] r_out_min;
    logic [HALF_BITS-1:0]   r_out_half;
    logic [TICK_BITS-1:0]   r_out_ticks;

    // config port
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decimation <= DECIMATION_RST;
            r_cfg.midpoint   <= MIDPOINT_RST;
            r_cfg.margin     <= MARGIN_RST;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                CFG_DECIMATION: r_cfg.decimation <= i_cfg_ch.data[DEC_BITS-1:0];
                CFG_MIDPOINT:   r_cfg.midpoint   <= i_cfg_ch.data[SAMPLE_BITS-1:0];
                CFG_MARGIN:     r_cfg.margin     <= i_cfg_ch.data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign i_sample_ch.ready = (r_state == ST_IDLE);
    assign in_fire           = i_sample_ch.valid && i_sample_ch.ready;
    assign scan_ctl.start    = in_fire && kept;
    assign scan_ctl.data     = i_sample_ch.sample;

    awfm_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (in_fire),
        .i_sample (i_sample_ch.sample),
        .o_kept   (kept),
        .o_sts    (trk_sts)
    );

    awfm_scan #(
        .WINDOW (WINDOW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .o_sts   (scan_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && !o_result_ch.ready;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = kept ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (scan_sts.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_result_ch.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_taken <= kept;
        end
        if (out_load) begin
            r_out_taken    <= r_taken;
            r_out_ovl      <= trk_sts.overload_seen;
            r_out_ovl_tick <= trk_sts.overload_tick;
            r_out_max      <= scan_sts.max;
            r_out_min      <= scan_sts.min;
            r_out_half     <= trk_sts.half_period;
            r_out_ticks    <= trk_sts.tick_count;
        end
    end

    assign o_result_ch.valid         = r_out_valid;
    assign o_result_ch.taken         = r_out_taken;
    assign o_result_ch.overload_seen = r_out_ovl;
    assign o_result_ch.overload_tick = r_out_ovl_tick;
    assign o_result_ch.window_max    = r_out_max;
    assign o_result_ch.window_min    = r_out_min;
    assign o_result_ch.half_period   = r_out_half;
    assign o_result_ch.tick_count    = r_out_ticks;

`ifndef SYNTHESIS
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_sts.done |-> r_state == ST_SCAN)
        else $error("sweep finished outside the scan state");
    a_skip_goes_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !kept |=> r_state == ST_FINISH && !r_taken)
        else $error("dropped tick did not go straight to the result");
    a_kept_goes_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && kept |=> r_state == ST_SCAN && r_taken)
        else $error("kept tick did not start a sweep");
`endif

endmodule

@@ dv/tb_adc_window_frequency_monitor.sv @@
// Self-checking bench for adc_window_frequency_monitor: predicts every result beat
// from the sample beats and register writes it sees; depends on awfm_pkg and awfm_if.
`timescale 1ns / 1ps

module tb_adc_window_frequency_monitor;
    import awfm_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int SEGMENT_ITEMS = 120;

    typedef struct packed {
        logic                   taken;
        logic                   overload_seen;
        logic [TICK_BITS-1:0]   overload_tick;
        logic [SAMPLE_BITS-1:0] window_max;
        logic [SAMPLE_BITS-1:0] window_min;
        logic [HALF_BITS-1:0]   half_period;
        logic [TICK_BITS-1:0]   tick_count;
    } t_meter_reading;

    // Tracks the meter's registers and state; one expected reading per sample beat.
    class freq_meter_board;
        logic [DEC_BITS-1:0]    decimation;
        logic [SAMPLE_BITS-1:0] midpoint;
        logic [SAMPLE_BITS-1:0] margin;
        logic [TICK_BITS-1:0]   tick_total;
        logic [DEC_BITS-1:0]    skip_count;
        logic [SAMPLE_BITS-1:0] window_codes [WINDOW_DEF];
        int                     slot;
        logic [SAMPLE_BITS-1:0] last_code;
        t_phase                 phase;
        logic [HALF_BITS-1:0]   run_count;
        logic [HALF_BITS-1:0]   last_half;
        logic                   ovl_flag;
        logic [TICK_BITS-1:0]   ovl_stamp;
        t_meter_reading         expected_readings [$];
        int                     errors;

        function new();
            decimation = DECIMATION_RST;
            midpoint   = MIDPOINT_RST;
            margin     = MARGIN_RST;
            tick_total = '0;
            skip_count = '0;
            foreach (window_codes[i]) window_codes[i] = '0;
            slot       = 0;
            last_code  = '0;
            phase      = PH_WAIT_RISE;
            run_count  = '0;
            last_half  = '0;
            ovl_flag   = 1'b0;
            ovl_stamp  = '0;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                CFG_DECIMATION: decimation = value[DEC_BITS-1:0];
                CFG_MIDPOINT:   midpoint   = value;
                CFG_MARGIN:     margin     = value;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] code);
            t_meter_reading r;
            logic [SAMPLE_BITS-1:0] hi, lo;
            int diff;
            r = '0;
            tick_total++;
            skip_count++;
            // a count already past a lowered decimation keeps the next tick
            if (skip_count >= decimation) begin
                skip_count = '0;
                r.taken = 1'b1;
                window_codes[slot] = code;
                slot = (slot + 1 >= WINDOW_DEF) ? 0 : slot + 1;
                diff = int'(code) - int'(midpoint);
                if (diff > int'(margin)) begin
                    ovl_flag  = 1'b1;
                    ovl_stamp = tick_total;
                end
                case (phase)
                    PH_COUNT: begin
                        if (run_count != HALF_MAX) run_count++;
                        if (last_code > midpoint && code < midpoint) phase = PH_STORE;
                    end
                    PH_STORE: begin
                        // no crossing test on this sample
                        last_half = run_count;
                        run_count = '0;
                        phase     = PH_WAIT_RISE;
                    end
                    default: begin
                        run_count = '0;
                        phase     = PH_WAIT_RISE;
                        if (last_code < midpoint && code > midpoint) phase = PH_COUNT;
                    end
                endcase
                last_code = code;
            end
            hi = '0;
            lo = '1;
            foreach (window_codes[i]) begin
                if (window_codes[i] > hi) hi = window_codes[i];
                if (window_codes[i] < lo) lo = window_codes[i];
            end
            r.overload_seen = ovl_flag;
            r.overload_tick = ovl_stamp;
            r.window_max    = hi;
            r.window_min    = lo;
            r.half_period   = last_half;
            r.tick_count    = tick_total;
            expected_readings.push_back(r);
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reading(t_meter_reading got);
            t_meter_reading want;
            if (expected_readings.size() == 0) begin
                $display("%0t: result beat with nothing expected: tick_count %0d",
                         $time, got.tick_count);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            check_field("taken", want.taken, got.taken);
            check_field("overload_seen", want.overload_seen, got.overload_seen);
            check_field("overload_tick", want.overload_tick, got.overload_tick);
            check_field("window_max", want.window_max, got.window_max);
            check_field("window_min", want.window_min, got.window_min);
            check_field("half_period", want.half_period, got.half_period);
            check_field("tick_count", want.tick_count, got.tick_count);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    awfm_in_if  sample_ch ();
    awfm_out_if result_ch ();
    awfm_cfg_if cfg_ch ();

    adc_window_frequency_monitor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch),
        .i_cfg_ch    (cfg_ch)
    );

    freq_meter_board board;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;
    logic [DEC_BITS-1:0]    code_dec = DECIMATION_RST;
    logic [SAMPLE_BITS-1:0] code_mid = MIDPOINT_RST;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        result_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sample_ch.valid && sample_ch.ready) board.note_sample(sample_ch.sample);
            if (cfg_ch.valid && cfg_ch.ready)
                board.write_reg(t_cfg_idx'(cfg_ch.index), cfg_ch.data);
            if (result_ch.valid && result_ch.ready)
                board.check_reading('{taken: result_ch.taken,
                                      overload_seen: result_ch.overload_seen,
                                      overload_tick: result_ch.overload_tick,
                                      window_max: result_ch.window_max,
                                      window_min: result_ch.window_min,
                                      half_period: result_ch.half_period,
                                      tick_count: result_ch.tick_count});
        end
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Called at a falling edge; leaves valid high so back-to-back beats need no toggle.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] code);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= code;
        do @(posedge i_clk); while (!sample_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do @(negedge i_clk); while (board.expected_readings.size() != 0);
    endtask

    task automatic cfg_beat(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [DEC_BITS-1:0] dec,
                              input logic [SAMPLE_BITS-1:0] mid,
                              input logic [SAMPLE_BITS-1:0] margin);
        cfg_beat(CFG_DECIMATION, CFG_DATA_BITS'(dec));
        cfg_beat(CFG_MIDPOINT, mid);
        cfg_beat(CFG_MARGIN, margin);
        cfg_ch.valid <= 1'b0;
        code_dec = dec;
        code_mid = mid;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] wave_code(int level);
        int v;
        v = level + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_BITS'(v);
    endfunction

    // square-ish wave around the midpoint, half period scaled by decimation up to 4
    task automatic send_wave();
        int half, amp, reps, scale;
        scale = (code_dec == 0 || code_dec > 4) ? 1 : int'(code_dec);
        half  = $urandom_range(1, 10) * scale;
        amp   = $urandom_range(1, 2047);
        reps  = $urandom_range(1, 4);
        repeat (reps) begin
            repeat (half) send_sample(wave_code(int'(code_mid) + amp));
            repeat (half) send_sample(wave_code(int'(code_mid) - amp));
        end
    endtask

    task automatic random_regs();
        logic [DEC_BITS-1:0]    dec;
        logic [SAMPLE_BITS-1:0] mid, margin;
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)      dec = 8'd1;
        else if (pick < 92) dec = DEC_BITS'($urandom_range(2, 4));
        else                dec = DEC_BITS'($urandom_range(5, 255));
        mid    = ($urandom_range(99) < 80) ? SAMPLE_BITS'($urandom_range(1024, 3072))
                                           : SAMPLE_BITS'($urandom);
        margin = ($urandom_range(1) == 0) ? SAMPLE_BITS'($urandom_range(0, 2047))
                                          : SAMPLE_BITS'($urandom);
        write_regs(dec, mid, margin);
    endtask

    task automatic run_segment(input int quota);
        int target;
        target = items_sent + quota;
        while (items_sent < target) begin
            if ($urandom_range(99) < 75)
                send_wave();
            else
                repeat ($urandom_range(1, 8)) send_sample(SAMPLE_BITS'($urandom));
            if ($urandom_range(99) == 0) wait_drained();
        end
    endtask

    initial begin
        board            = new();
        i_rst_n          = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_DECIMATION;
        cfg_ch.data      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: rise, count, fall, store, then samples on the midpoint
        send_sample(12'd0);
        send_sample(12'd3000);
        send_sample(12'd3000);
        send_sample(12'd1000);
        send_sample(12'd500);
        send_sample(12'd2048);
        send_sample(12'd4095);
        send_sample(12'd2048);
        send_sample(12'd0);
        wait_drained();

        // zero decimation keeps every tick; zero margin overloads on any code above 0
        write_regs(8'd0, 12'd0, 12'd0);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd4095);
        wait_drained();

        write_regs(8'd10, 12'd4095, 12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'd4095);
        wait_drained();

        // count is now above the new decimation
        write_regs(8'd2, 12'd2048, 12'd1000);
        send_sample(12'd3100);
        wait_drained();

        write_regs(8'd255, 12'd2048, 12'd2047);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd2049);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            repeat (2) begin
                wait_drained();
                random_regs();
                run_segment(SEGMENT_ITEMS);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.expected_readings.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
